[sv/gdc_pkg.sv]
`timescale 1ns / 1ps
package gdc_pkg;

   localparam int unsigned SecsInDay = 86400;
   localparam int unsigned DaysIn400 = 146097;
   localparam int unsigned DaysIn100 = 36524;
   localparam int unsigned DaysIn4 = 1461;
   localparam int unsigned DaysIn1 = 365;
   localparam int unsigned YearMax = 16383;

   typedef struct packed {
      logic        mode;
      logic [13:0] in_year;
      logic [3:0]  in_month;
      logic [4:0]  in_day;
      logic [4:0]  in_hour;
      logic [5:0]  in_minute;
      logic [5:0]  in_second;
      logic [38:0] in_total_seconds;
   } req_type;

   typedef struct packed {
      logic [38:0] out_total_seconds;
      logic [13:0] out_year;
      logic [3:0]  out_month;
      logic [4:0]  out_day;
      logic [4:0]  out_hour;
      logic [5:0]  out_minute;
      logic [5:0]  out_second;
      logic [2:0]  weekday;
      logic        valid_res;
   } rsp_type;

   // one step per command
   typedef struct packed {
      logic load;
      logic step;
      logic [4:0] op;
   } cmd_type;

   typedef struct packed {
      logic done;
   } sts_type;

   localparam logic [4:0] OpLoad   = 5'd0;
   localparam logic [4:0] OpTod    = 5'd1;
   localparam logic [4:0] OpDays   = 5'd2;
   localparam logic [4:0] OpMul    = 5'd3;
   localparam logic [4:0] OpTotal  = 5'd4;
   localparam logic [4:0] OpDiv    = 5'd5;
   localparam logic [4:0] OpDivFix = 5'd6;
   localparam logic [4:0] OpQ400   = 5'd7;
   localparam logic [4:0] OpQ100   = 5'd8;
   localparam logic [4:0] OpQ4     = 5'd9;
   localparam logic [4:0] OpQ1     = 5'd10;
   localparam logic [4:0] OpMonth  = 5'd11;
   localparam logic [4:0] OpClock  = 5'd12;
   localparam logic [4:0] OpFinish = 5'd13;

   function automatic logic leap_year(input logic [15:0] y);
      logic [15:0] q4;
      logic [15:0] q100;
      logic [15:0] q400;
      q4 = y >> 2;
      q100 = 16'((32'(y) * 32'd5243) >> 19);
      q400 = q100 >> 2;
      return ((y - 16'(q100 * 16'd100)) == 16'd0) ? ((q100 - (q400 << 2)) == 16'd0)
         : ((y - (q4 << 2)) == 16'd0);
   endfunction

   function automatic logic [4:0] month_length(input logic [15:0] y, input logic [3:0] m);
      logic [4:0] r;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
         4'd2: r = leap_year(y) ? 5'd29 : 5'd28;
         default: r = 5'd0;
      endcase
      return r;
   endfunction

endpackage

[sv/gdc_if.sv]
`timescale 1ns / 1ps
interface gdc_req_if;
   logic valid;
   logic ready;
   gdc_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface gdc_rsp_if;
   logic valid;
   logic ready;
   gdc_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[sv/gdc_datapath.sv]
`timescale 1ns / 1ps
module gdc_datapath (
   input  logic              clock,
   input  gdc_pkg::cmd_type  cmd,
   input  gdc_pkg::req_type  req,
   output gdc_pkg::rsp_type  rsp
);

   logic [38:0] total_ff, total_in;
   logic [16:0] tod_ff, tod_in;
   logic [22:0] days_ff, days_in;
   logic [22:0] r_ff, r_in;
   logic [15:0] year_ff, year_in;
   logic [3:0]  month_ff, month_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        valid_ff, valid_in;
   logic        ok_ff, ok_in;
   logic [63:0] prod_ff, prod_in;
   gdc_pkg::req_type req_ff, req_in;
   gdc_pkg::rsp_type rsp_ff, rsp_in;

   logic [15:0] n_year;
   logic [4:0]  len;
   logic [16:0] t_raw;
   logic [22:0] q;
   logic [22:0] qt;
   logic [4:0]  hr;
   logic [16:0] rem_h;
   logic [5:0]  mn;
   logic [2:0]  wd;

   assign n_year = 16'(req.in_year) - 16'd1;
   assign len = gdc_pkg::month_length(year_ff, month_ff);
   assign t_raw = 17'(req.in_hour) * 17'd3600 + 17'(req.in_minute) * 17'd60
      + 17'(req.in_second);
   assign hr = 5'((32'(tod_ff) * 32'd37283) >> 27);
   assign rem_h = tod_ff - 17'(hr) * 17'd3600;
   assign mn = 6'((32'(rem_h) * 32'd34953) >> 21);
   assign q = 23'(prod_ff);
   assign wd = 3'((32'(days_ff + 23'd1) - 32'((64'(days_ff + 23'd1) * 64'd613566757) >> 32)
      * 32'd7) & 32'd7);

   always_comb begin
      total_in = total_ff;
      tod_in = tod_ff;
      days_in = days_ff;
      r_in = r_ff;
      year_in = year_ff;
      month_in = month_ff;
      cnt_in = cnt_ff;
      valid_in = valid_ff;
      ok_in = ok_ff;
      prod_in = prod_ff;
      req_in = req_ff;
      rsp_in = rsp_ff;
      qt = 23'd0;
      if (cmd.load) begin
         req_in = req;
      end
      if (cmd.step) begin
         case (cmd.op)
            gdc_pkg::OpLoad: begin
               year_in = 16'(req.in_year);
               month_in = 4'd1;
               r_in = 23'((32'(n_year) * 32'd365) + 32'(n_year >> 2));
               cnt_in = 5'd0;
               tod_in = (t_raw > 17'(gdc_pkg::SecsInDay)) ? 17'(gdc_pkg::SecsInDay) : t_raw;
               ok_in = req.in_year != 14'd0 && req.in_month >= 4'd1 && req.in_month <= 4'd12
                  && req.in_day != 5'd0
                  && req.in_day <= gdc_pkg::month_length(16'(req.in_year), req.in_month);
               prod_in = 64'((32'(n_year) * 32'd5243) >> 19);
            end
            gdc_pkg::OpTod: begin
               r_in = r_ff - 23'(prod_ff[15:0]) + 23'(prod_ff[15:2]);
               days_in = 23'(req_ff.in_day) - 23'd1;
            end
            gdc_pkg::OpDays: begin
               if (month_ff < req_ff.in_month) begin
                  days_in = days_ff + 23'(len);
                  month_in = month_ff + 4'd1;
               end
            end
            gdc_pkg::OpMul: prod_in = 64'(r_ff + days_ff) * 64'(gdc_pkg::SecsInDay);
            gdc_pkg::OpTotal: begin
               if (req_ff.mode) begin
                  total_in = req_ff.in_total_seconds;
                  valid_in = 1'b1;
               end else if (ok_ff) begin
                  total_in = 39'(prod_ff) + 39'(tod_ff);
                  valid_in = tod_ff < 17'(gdc_pkg::SecsInDay);
               end else begin
                  total_in = 39'd0;
                  valid_in = 1'b0;
               end
            end
            gdc_pkg::OpDiv: prod_in = (64'(total_ff[38:7]) * 64'd3257812231) >> 41;
            gdc_pkg::OpDivFix: begin
               days_in = q;
               tod_in = 17'(total_ff - 39'(q) * 39'(gdc_pkg::SecsInDay));
            end
            gdc_pkg::OpQ400: begin
               qt = 23'((64'(days_ff) * 64'd7525902) >> 40);
               year_in = 16'(qt * 23'd400);
               r_in = days_ff - 23'(32'(qt) * 32'(gdc_pkg::DaysIn400));
               if (r_in >= 23'(gdc_pkg::DaysIn400)) begin
                  r_in = r_in - 23'(gdc_pkg::DaysIn400);
                  year_in = year_in + 16'd400;
               end
            end
            gdc_pkg::OpQ100: begin
               if (cnt_ff < 5'd3 && r_ff >= 23'(gdc_pkg::DaysIn100)) begin
                  r_in = r_ff - 23'(gdc_pkg::DaysIn100);
                  year_in = year_ff + 16'd100;
                  cnt_in = cnt_ff + 5'd1;
               end
            end
            gdc_pkg::OpQ4: begin
               qt = 23'((32'(r_ff) * 32'd45934) >> 26);
               r_in = r_ff - 23'(32'(qt) * 32'(gdc_pkg::DaysIn4));
               year_in = year_ff + 16'(qt << 2);
               cnt_in = 5'd0;
            end
            gdc_pkg::OpQ1: begin
               if (cnt_ff < 5'd3 && r_ff >= 23'(gdc_pkg::DaysIn1)) begin
                  r_in = r_ff - 23'(gdc_pkg::DaysIn1);
                  year_in = year_ff + 16'd1;
                  cnt_in = cnt_ff + 5'd1;
               end else if (cnt_ff != 5'd31) begin
                  year_in = year_ff + 16'd1;
                  month_in = 4'd1;
                  cnt_in = 5'd31;
               end
            end
            gdc_pkg::OpMonth: begin
               if (month_ff < 4'd12 && r_ff >= 23'(len)) begin
                  r_in = r_ff - 23'(len);
                  month_in = month_ff + 4'd1;
               end
            end
            gdc_pkg::OpClock: ;
            gdc_pkg::OpFinish: begin
               rsp_in.out_total_seconds = total_ff;
               rsp_in.weekday = wd + 3'd1;
               if (year_ff > 16'(gdc_pkg::YearMax)) begin
                  rsp_in.out_year = 14'd0;
                  rsp_in.out_month = 4'd0;
                  rsp_in.out_day = 5'd0;
                  rsp_in.out_hour = 5'd0;
                  rsp_in.out_minute = 6'd0;
                  rsp_in.out_second = 6'd0;
                  rsp_in.valid_res = 1'b0;
               end else begin
                  rsp_in.out_year = year_ff[13:0];
                  rsp_in.out_month = month_ff;
                  rsp_in.out_day = 5'(r_ff + 23'd1);
                  rsp_in.out_hour = hr;
                  rsp_in.out_minute = mn;
                  rsp_in.out_second = 6'(rem_h - 17'(mn) * 17'd60);
                  rsp_in.valid_res = valid_ff;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      total_ff <= total_in;
      tod_ff <= tod_in;
      days_ff <= days_in;
      r_ff <= r_in;
      year_ff <= year_in;
      month_ff <= month_in;
      cnt_ff <= cnt_in;
      valid_ff <= valid_in;
      ok_ff <= ok_in;
      prod_ff <= prod_in;
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp = rsp_ff;

endmodule

[sv/gdc_ctrl.sv]
`timescale 1ns / 1ps
module gdc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output gdc_pkg::cmd_type cmd
);

   localparam logic [1:0] StIdle = 2'd0;
   localparam logic [1:0] StRun  = 2'd1;
   localparam logic [1:0] StOut  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [4:0] op_ff, op_in;
   logic [3:0] rep_ff, rep_in;
   logic [3:0] reps;

   always_comb begin
      case (op_ff)
         gdc_pkg::OpDays: reps = 4'd11;
         gdc_pkg::OpQ100: reps = 4'd2;
         gdc_pkg::OpQ1: reps = 4'd3;
         gdc_pkg::OpMonth: reps = 4'd11;
         default: reps = 4'd0;
      endcase
   end

   assign req_ready = state_ff == StIdle;
   assign rsp_valid = state_ff == StOut;

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      rep_in = rep_ff;
      cmd.load = 1'b0;
      cmd.step = 1'b0;
      cmd.op = op_ff;
      case (state_ff)
         StIdle: begin
            if (req_valid) begin
               cmd.step = 1'b1;
               cmd.load = 1'b1;
               cmd.op = gdc_pkg::OpLoad;
               op_in = gdc_pkg::OpTod;
               rep_in = 4'd0;
               state_in = StRun;
            end
         end
         StRun: begin
            cmd.step = 1'b1;
            if (rep_ff < reps) begin
               rep_in = rep_ff + 4'd1;
            end else begin
               rep_in = 4'd0;
               op_in = op_ff + 5'd1;
               if (op_ff == gdc_pkg::OpFinish) begin
                  state_in = StOut;
               end
            end
         end
         StOut: begin
            if (rsp_ready) begin
               state_in = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         op_ff <= gdc_pkg::OpLoad;
         rep_ff <= 4'd0;
      end else begin
         state_ff <= state_in;
         op_ff <= op_in;
         rep_ff <= rep_in;
      end
   end

endmodule

[sv/gregorian_datetime_converter.sv]
`timescale 1ns / 1ps
// requests: one at a time; a new request is accepted only after the response is taken
// the command sequence includes two month walks plus the century and year steps
// reset: synchronous active high, returns the controller to idle
// no response is pending after reset
module gregorian_datetime_converter (
   input logic clock,
   input logic reset,
   gdc_req_if.sink   req,
   gdc_rsp_if.source rsp
);

   gdc_pkg::cmd_type cmd;

   gdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd)
   );

   gdc_datapath u_datapath (
      .clock (clock),
      .cmd   (cmd),
      .req   (req.data),
      .rsp   (rsp.data)
   );

`ifndef NO_ASSERTIONS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready) else $error("accept while busy");
   a_weekday: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.data.weekday != 3'd0)) else $error("bad weekday");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid) else $error("response dropped");
`endif

endmodule
